FILE: rtl/ppru_pkg.sv
// Shared types and constants for the packed pixel row unpacker.
`timescale 1ns / 1ps

package ppru_pkg;

    localparam int WORD_W      = 16;
    localparam int VBITS_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CARRY_W     = 8;
    localparam int PHASE_W     = 2;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_VALID_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT  = 2'd2;

    // Reset values of the registers
    localparam logic [VBITS_W-1:0] RESET_VALID_BITS = 5'd12;
    localparam logic [WORD_W-1:0]  RESET_ROW_WIDTH  = 16'd1;
    localparam logic [WORD_W-1:0]  RESET_ROW_COUNT  = 16'd1;

    // Unpack modes
    localparam logic [1:0] MODE_8  = 2'd0;
    localparam logic [1:0] MODE_12 = 2'd1;
    localparam logic [1:0] MODE_16 = 2'd2;

    // 12-bit group positions
    localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_THIRD  = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [WORD_W-1:0] eff_width;
        logic [WORD_W-1:0] eff_count;
        logic              restart;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] pixel;
        logic              row_end;
        logic              frame_end;
        logic              run_last;
    } result_t;

endpackage

FILE: rtl/ppru_cfg.sv
// Configuration registers, mode decode and frame restart pulse.
`timescale 1ns / 1ps

module ppru_cfg
    import ppru_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [WORD_W-1:0]      wr_data,
    output cfg_t                   cfg
);

    logic [VBITS_W-1:0] valid_bits_reg;
    logic [WORD_W-1:0]  row_width_reg;
    logic [WORD_W-1:0]  row_count_reg;
    logic               restart_reg;
    logic               known_index;

    assign known_index = (wr_index == REG_VALID_BITS) || (wr_index == REG_ROW_WIDTH)
                         || (wr_index == REG_ROW_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg <= RESET_VALID_BITS;
            row_width_reg  <= RESET_ROW_WIDTH;
            row_count_reg  <= RESET_ROW_COUNT;
            restart_reg    <= 1'b0;
        end
        else
        begin
            // restart is registered, so it lands in the cycle after the write and sees the new values
            restart_reg <= wr_en && known_index;
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_VALID_BITS: valid_bits_reg <= wr_data[VBITS_W-1:0];
                    REG_ROW_WIDTH:  row_width_reg  <= wr_data;
                    REG_ROW_COUNT:  row_count_reg  <= wr_data;
                    default:        ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (valid_bits_reg <= 5'd8)
            cfg.mode = MODE_8;
        else if (valid_bits_reg <= 5'd12)
            cfg.mode = MODE_12;
        else
            cfg.mode = MODE_16;
        cfg.eff_width = (row_width_reg == '0) ? 16'd1 : row_width_reg;
        cfg.eff_count = (row_count_reg == '0) ? 16'd1 : row_count_reg;
        cfg.restart   = restart_reg;
    end

endmodule

FILE: rtl/ppru_unpack.sv
// Row state and the per-result pixel extraction.
`timescale 1ns / 1ps

module ppru_unpack
    import ppru_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              step,
    input  logic              sub,
    input  logic [WORD_W-1:0] word,
    output result_t           res
);

    logic [WORD_W-1:0]  pixels_left_reg, pixels_left_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic [WORD_W-1:0]  rows_done_reg, rows_done_next;

    logic [WORD_W-1:0]  value;
    logic [PHASE_W-1:0] phase_mid;
    logic               two;
    logic [WORD_W-1:0]  pl_dec;
    logic [WORD_W:0]    rows_inc;

    always_comb
    begin
        value     = word;
        phase_mid = phase_reg;
        carry_next = carry_reg;
        two       = 1'b0;
        if (sub)
        begin
            // second result of a word
            value = (cfg.mode == MODE_8) ? {8'h00, word[15:8]} : {4'h0, word[15:4]};
        end
        else
        begin
            unique case (cfg.mode)
                MODE_8:
                begin
                    value = {8'h00, word[7:0]};
                    two   = (pixels_left_reg >= 16'd2);
                end
                MODE_12:
                begin
                    unique case (phase_reg)
                        PHASE_FIRST:
                        begin
                            if (pixels_left_reg >= 16'd4)
                            begin
                                value      = {4'h0, word[11:0]};
                                carry_next = {4'h0, word[15:12]};
                                phase_mid  = PHASE_SECOND;
                            end
                        end
                        PHASE_SECOND:
                        begin
                            value      = {4'h0, word[7:0], carry_reg[3:0]};
                            carry_next = word[15:8];
                            phase_mid  = PHASE_THIRD;
                        end
                        default:
                        begin
                            value      = {4'h0, word[3:0], carry_reg};
                            carry_next = '0;
                            phase_mid  = PHASE_FIRST;
                            two        = 1'b1;
                        end
                    endcase
                end
                default: value = word;
            endcase
        end

        pl_dec   = (pixels_left_reg != '0) ? pixels_left_reg - 16'd1 : '0;
        rows_inc = {1'b0, rows_done_reg} + 17'd1;

        res.pixel     = value;
        res.row_end   = (pl_dec == '0);
        res.frame_end = 1'b0;
        res.run_last  = sub || !two;
        pixels_left_next = pl_dec;
        phase_next       = phase_mid;
        rows_done_next   = rows_done_reg;
        if (pl_dec == '0)
        begin
            res.frame_end    = (rows_inc >= {1'b0, cfg.eff_count});
            rows_done_next   = res.frame_end ? '0 : rows_inc[WORD_W-1:0];
            pixels_left_next = cfg.eff_width;
            phase_next       = PHASE_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_left_reg <= RESET_ROW_WIDTH;
            phase_reg       <= PHASE_FIRST;
            carry_reg       <= '0;
            rows_done_reg   <= '0;
        end
        else if (cfg.restart)
        begin
            pixels_left_reg <= cfg.eff_width;
            phase_reg       <= PHASE_FIRST;
            carry_reg       <= '0;
            rows_done_reg   <= '0;
        end
        else if (step)
        begin
            pixels_left_reg <= pixels_left_next;
            phase_reg       <= phase_next;
            carry_reg       <= carry_next;
            rows_done_reg   <= rows_done_next;
        end
    end

endmodule

FILE: rtl/packed_pixel_row_unpacker_unit.sv
// Top level of the packed pixel row unpacker.
//
// Input channel data_word/data_valid/data_stall carries 16-bit little-endian
// words of a packed pixel stream; a transfer happens when data_valid is high
// and data_stall is low. Output channel pixel/row_end/frame_end/run_last with
// pixel_valid/pixel_stall gives one pixel per transfer, row_end and frame_end
// on the last pixel of a row and of a frame, run_last on the last pixel that
// a word produces.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 valid_bits,
// 1 row_width, 2 row_count) and cfg_data; cfg_ready is always high. Any write
// to a known register restarts the frame. Write only while the block is idle.
// Path: a transferred word is held in the word register, then each of its
// pixels is loaded into the output register.
// Throughput: one pixel per cycle from a single output register while the
// output is not stalled; a word holding two pixels (8-bit mode, third word of
// a 12-bit group) stays in the word register until both pixels have advanced.
// Reset: registers go to valid_bits 12, row_width 1, row_count 1, row state
// cleared, both channels empty. When pixel_stall is high the output holds and
// data_stall rises as soon as the word register cannot drain.
`timescale 1ns / 1ps

module packed_pixel_row_unpacker_unit
    import ppru_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    input  logic                   data_valid,
    output logic                   data_stall,
    input  logic [WORD_W-1:0]      data_word,
    output logic                   pixel_valid,
    input  logic                   pixel_stall,
    output logic [WORD_W-1:0]      pixel,
    output logic                   row_end,
    output logic                   frame_end,
    output logic                   run_last
);

    cfg_t    cfg;
    result_t res;
    result_t out_reg;

    logic              item_valid_reg;
    logic              item_sub_reg;
    logic [WORD_W-1:0] item_word_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              item_done;
    logic              accept;

    assign cfg_ready = 1'b1;

    ppru_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ppru_unpack u_unpack (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .sub   (item_sub_reg),
        .word  (item_word_reg),
        .res   (res)
    );

    assign advance    = item_valid_reg && (!out_valid_reg || !pixel_stall);
    assign item_done  = advance && res.run_last;
    assign data_stall = item_valid_reg && !item_done;
    assign accept     = data_valid && !data_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            item_sub_reg   <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
            item_sub_reg   <= 1'b0;
        end
        else if (item_done)
        begin
            item_valid_reg <= 1'b0;
            item_sub_reg   <= 1'b0;
        end
        else if (advance)
        begin
            item_sub_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_word_reg <= data_word;
        if (advance)
            out_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!pixel_stall)
            out_valid_reg <= 1'b0;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg.pixel;
    assign row_end     = out_reg.row_end;
    assign frame_end   = out_reg.frame_end;
    assign run_last    = out_reg.run_last;

    // An empty word register never holds off the input.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> !data_stall)
        else $error("input stalled with empty word register");

    // The second pixel of a word follows its first without a gap.
    a_pair_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall && !run_last) |=> pixel_valid)
        else $error("second pixel of a word missing");

    // A frame ends only on a row end.
    a_frame_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (!frame_end || row_end))
        else $error("frame end without row end");

endmodule
